// ===== rtl/smes_pkg.sv =====
// shared types and constants for the sparse matrix element store
// no dependencies; imported by smes_cell, sparse_matrix_element_store and the testbench
package smes_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 64;
	localparam int IDX16_W    = 16;
	localparam int CNT_W      = 7;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_PAD_W  = OUT_DATA_W - (VAL_W + 1 + 2 + CNT_W);
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS       = 8'd0,
		REG_NUM_COLUMNS    = 8'd1,
		REG_DEFAULT_VALUE  = 8'd2,
		REG_CAPACITY_LIMIT = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_APPLY
	} state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic occ;
		logic append;
		logic update;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/smes_cell.sv =====
// one storage cell of the entry chain: a key/value pair and its key compare
// depends on smes_pkg
module smes_cell (
	input  logic                        clk,
	input  smes_pkg::cell_ctrl_t        ctrl,
	input  logic [smes_pkg::KEY_W-1:0]  query_key,
	input  logic [smes_pkg::KEY_W-1:0]  new_key,
	input  logic [smes_pkg::VAL_W-1:0]  new_value,
	input  logic [smes_pkg::KEY_W-1:0]  next_key,
	input  logic [smes_pkg::VAL_W-1:0]  next_value,
	output logic                        match,
	output logic [smes_pkg::KEY_W-1:0]  key,
	output logic [smes_pkg::VAL_W-1:0]  value
);
	import smes_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctrl.update) begin
			value_q <= new_value;
		end else if (ctrl.shift) begin
			// delete closes the gap: take the upper neighbor's entry
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

	assign match = ctrl.occ && (key_q == query_key);
	assign key   = key_q;
	assign value = value_q;

endmodule

// ===== rtl/sparse_matrix_element_store.sv =====
// sparse matrix element store: a chain of key/value cells with a small sequencer
// depends on smes_pkg and smes_cell
//
// Usage
//   s_* channel: one request per transfer. s_tuser = func (0 read, 1 write);
//   s_tdata = row, col, write_value. The key row*num_columns+col is formed on
//   the accepting edge together with the row/column range check.
//   m_* channel: one result per request: read_value, found, status, entry_total.
//   cfg_* channel: register writes (0 num_rows, 1 num_columns, 2 default_value,
//   3 capacity_limit), always ready; write only while no request is in flight.
// Timing
//   a request is accepted in the idle state, all cells compare the key in
//   parallel in the next cycle, and the cells are updated and the result is
//   registered in the apply state once the output register is free. A new
//   request is taken only after the current one has left the apply state.
//   Deletes shift the entries above the freed slot down one cell in that update.
// Reset clears the entry count (store empty) and loads the register defaults;
//   cell contents are not cleared and are only read below the count.
// When the receiver stalls the result stays in the output register; one more
//   request is still taken and held in its update cycle until the register frees.
module sparse_matrix_element_store #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [15:0] row, [31:16] col, [95:32] write_value
	input  logic [smes_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] func
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [63:0] read_value, [64] found, [66:65] status, [73:67] entry_total, rest zero
	output logic [smes_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [smes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [smes_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import smes_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// configuration
	logic [IDX16_W-1:0] num_rows_q;
	logic [IDX16_W-1:0] num_columns_q;
	logic [VAL_W-1:0]   default_value_q;
	logic [CNT_W-1:0]   capacity_limit_q;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// request registers
	logic               func_q;
	logic               oor_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   wval_q;

	// lookup results
	logic               hit_q;
	logic [VAL_W-1:0]   rdval_q;
	logic [IDX_W-1:0]   slot_q;
	logic               nondef_q;

	logic [IDX16_W-1:0] row, col;
	logic [KEY_W-1:0]   row_prod;
	logic [KEY_W-1:0]   key_in;
	logic               oor_in;
	logic               in_xfer;

	logic [CAPACITY-1:0]  match;
	logic [KEY_W-1:0]     cell_key   [CAPACITY];
	logic [VAL_W-1:0]     cell_value [CAPACITY];
	cell_ctrl_t           cell_ctrl  [CAPACITY];
	logic [VAL_W-1:0]     look_value;
	logic [IDX_W-1:0]     look_slot;

	logic [CNT_W-1:0]   limit;
	logic               commit;
	logic               do_update, do_append, do_delete, is_full;
	logic [1:0]         status;
	logic               found;
	logic [VAL_W-1:0]   rd_value;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q       <= IDX16_W'(1);
			num_columns_q    <= IDX16_W'(1);
			default_value_q  <= '0;
			capacity_limit_q <= CNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_ROWS:       num_rows_q       <= cfg_data[IDX16_W-1:0];
				REG_NUM_COLUMNS:    num_columns_q    <= cfg_data[IDX16_W-1:0];
				REG_DEFAULT_VALUE:  default_value_q  <= cfg_data;
				REG_CAPACITY_LIMIT: capacity_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// key and range check straight from the request
	assign row      = s_tdata[15:0];
	assign col      = s_tdata[31:16];
	assign row_prod = KEY_W'(row) * KEY_W'(num_columns_q);
	assign key_in   = row_prod + KEY_W'(col);
	assign oor_in   = (row >= num_rows_q) || (col >= num_columns_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= s_tuser;
			oor_q  <= oor_in;
			key_q  <= key_in;
			wval_q <= s_tdata[95:32];
		end
	end

	// parallel lookup: keys are unique among stored entries, so at most one match
	always_comb begin
		look_value = '0;
		look_slot  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			look_value = look_value | ({VAL_W{match[i]}} & cell_value[i]);
			look_slot  = look_slot | (match[i] ? IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			hit_q    <= |match;
			rdval_q  <= look_value;
			slot_q   <= look_slot;
			nondef_q <= (wval_q != default_value_q);
		end
	end

	always_comb begin
		if (int'(capacity_limit_q) < CAPACITY)
			limit = capacity_limit_q;
		else
			limit = CNT_W'(CAPACITY);
	end

	assign commit    = (state_q == ST_APPLY) && (!out_valid_q || m_tready);
	assign do_update = !oor_q && func_q && nondef_q && hit_q;
	assign do_append = !oor_q && func_q && nondef_q && !hit_q && (count_q < limit);
	assign is_full   = !oor_q && func_q && nondef_q && !hit_q && !(count_q < limit);
	assign do_delete = !oor_q && func_q && !nondef_q && hit_q;

	always_comb begin
		status   = STATUS_OK;
		found    = 1'b0;
		rd_value = '0;
		if (oor_q) begin
			status = STATUS_RANGE;
		end else begin
			found = hit_q;
			if (!func_q)
				rd_value = hit_q ? rdval_q : default_value_q;
			if (is_full)
				status = STATUS_FULL;
		end
	end

	always_comb begin
		count_d = count_q;
		if (commit && do_append)
			count_d = count_q + CNT_W'(1);
		else if (commit && do_delete)
			count_d = count_q - CNT_W'(1);
	end

	// entry chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctrl[i].occ    = int'(count_q) > i;
		assign cell_ctrl[i].append = commit && do_append && (int'(count_q) == i);
		assign cell_ctrl[i].update = commit && do_update && (slot_q == IDX_W'(i));
		assign cell_ctrl[i].shift  = commit && do_delete && (int'(slot_q) <= i);

		if (i == CAPACITY - 1) begin : g_top
			smes_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.query_key  (key_q),
				.new_key    (key_q),
				.new_value  (wval_q),
				.next_key   (cell_key[i]),
				.next_value (cell_value[i]),
				.match      (match[i]),
				.key        (cell_key[i]),
				.value      (cell_value[i])
			);
		end else begin : g_mid
			smes_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.query_key  (key_q),
				.new_key    (key_q),
				.new_value  (wval_q),
				.next_key   (cell_key[i+1]),
				.next_value (cell_value[i+1]),
				.match      (match[i]),
				.key        (cell_key[i]),
				.value      (cell_value[i])
			);
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_xfer) state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_APPLY;
			ST_APPLY: if (commit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit)
			out_data_q <= {{OUT_PAD_W{1'b0}}, count_d, status, found, rd_value};
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("entry count beyond cell chain");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> $onehot0(match))
		else $error("key held by more than one cell");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == ST_APPLY)
		else $error("entry count changed outside update cycle");

	a_result_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY && commit |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not registered after update");

endmodule

// ===== dv/sparse_matrix_element_store_test.sv =====
// self-checking testbench for sparse_matrix_element_store: directed and random element
// reads and writes checked against an in-bench model of the key/value table
// depends on smes_pkg and the sparse_matrix_element_store rtl
`timescale 1ns / 1ps

module sparse_matrix_element_store_test;
	import smes_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int STALL_LIMIT = 2000;
	localparam bit FUNC_READ   = 1'b0;
	localparam bit FUNC_WRITE  = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             found;
		logic [1:0]       status;
		logic [CNT_W-1:0] entry_total;
	} element_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sparse_matrix_element_store #(.CAPACITY(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the block's registers and table
	logic [15:0]      cur_rows;
	logic [15:0]      cur_cols;
	logic [VAL_W-1:0] cur_default;
	logic [CNT_W-1:0] cur_limit;
	logic [KEY_W-1:0] entry_keys [STORE_DEPTH];
	logic [VAL_W-1:0] entry_values [STORE_DEPTH];
	int               live_entries;

	element_result_t pending_results [$];

	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned read_count;
	int unsigned write_count;
	int unsigned range_count;
	int unsigned full_count;
	int unsigned delete_count;
	int          peak_entries;
	bit          src_calm;
	int unsigned sink_hold;

	logic [VAL_W-1:0] value_pool [4] = '{64'h0, {VAL_W{1'b1}}, 64'h8000_0000_0000_0000, 64'h1};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic element_result_t predict_access(bit func, logic [15:0] row,
			logic [15:0] col, logic [VAL_W-1:0] wval);
		element_result_t res;
		logic [KEY_W-1:0] key;
		int slot;
		int room;
		res = '0;
		if (func == FUNC_READ)
			read_count++;
		else
			write_count++;
		if (row >= cur_rows || col >= cur_cols) begin
			res.status = STATUS_RANGE;
			range_count++;
		end else begin
			key = 32'(row) * 32'(cur_cols) + 32'(col);
			slot = -1;
			for (int i = 0; i < live_entries; i++)
				if (slot < 0 && entry_keys[i] == key)
					slot = i;
			res.found = (slot >= 0);
			room = (cur_limit < STORE_DEPTH) ? int'(cur_limit) : STORE_DEPTH;
			if (func == FUNC_READ) begin
				res.read_value = (slot >= 0) ? entry_values[slot] : cur_default;
			end else if (wval != cur_default) begin
				if (slot >= 0) begin
					entry_values[slot] = wval;
				end else if (live_entries < room) begin
					entry_keys[live_entries] = key;
					entry_values[live_entries] = wval;
					live_entries++;
				end else begin
					res.status = STATUS_FULL;
					full_count++;
				end
			end else if (slot >= 0) begin
				// delete: last entry moves into the freed slot
				entry_keys[slot] = entry_keys[live_entries-1];
				entry_values[slot] = entry_values[live_entries-1];
				live_entries--;
				delete_count++;
			end
		end
		if (live_entries > peak_entries)
			peak_entries = live_entries;
		res.entry_total = 7'(live_entries);
		return res;
	endfunction

	task automatic send_element(bit func, logic [15:0] row, logic [15:0] col,
			logic [VAL_W-1:0] wval);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {wval, col, row};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_access(func, row, col, wval));
	endtask

	// drain everything in flight so registers can be rewritten safely
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_NUM_ROWS: cur_rows = data[15:0];
			REG_NUM_COLUMNS: cur_cols = data[15:0];
			REG_DEFAULT_VALUE: cur_default = data;
			REG_CAPACITY_LIMIT: cur_limit = data[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int n);
		bit               func;
		logic [15:0]      row;
		logic [15:0]      col;
		logic [VAL_W-1:0] wval;
		int unsigned      pick;
		int unsigned      rspan;
		int unsigned      cspan;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 31) == 0)
				src_calm = !src_calm;
			func = ($urandom_range(0, 99) < 55) ? FUNC_WRITE : FUNC_READ;
			rspan = (cur_rows > 10) ? 9 : cur_rows - 1;
			cspan = (cur_cols > 10) ? 9 : cur_cols - 1;
			pick = $urandom_range(0, 99);
			if (pick < 10 || cur_rows == 0 || cur_cols == 0) begin
				// full-width indices, mostly out of range on the small grids
				row = 16'($urandom);
				col = 16'($urandom);
			end else begin
				row = ($urandom_range(0, 6) == 0) ? cur_rows - 16'd1
					: 16'($urandom_range(0, rspan));
				col = ($urandom_range(0, 6) == 0) ? cur_cols - 16'd1
					: 16'($urandom_range(0, cspan));
			end
			pick = $urandom_range(0, 9);
			if (pick < 3)
				wval = cur_default;
			else if (pick < 6)
				wval = value_pool[$urandom_range(0, 3)];
			else
				wval = {$urandom, $urandom};
			send_element(func, row, col, wval);
		end
	endtask

	task automatic test_basic_access();
		send_element(FUNC_READ, 16'd0, 16'd0, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd0, {VAL_W{1'b1}});
		send_element(FUNC_READ, 16'd0, 16'd0, {$urandom, $urandom});
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h8000_0000_0000_0001);
		send_element(FUNC_READ, 16'd1, 16'd0, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd1, 64'h1234);
		send_element(FUNC_WRITE, 16'hFFFF, 16'hFFFF, {$urandom, $urandom});
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h0);
		// delete of a key that is no longer stored
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h0);
	endtask

	task automatic test_capacity_and_delete();
		settle();
		// upper bits of a narrow register are junk on purpose
		write_register(REG_NUM_ROWS, {32'($urandom), 16'($urandom), 16'd4});
		write_register(REG_NUM_COLUMNS, 64'd4);
		write_register(REG_DEFAULT_VALUE, {VAL_W{1'b1}});
		write_register(REG_CAPACITY_LIMIT, 64'd2);
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h1);
		send_element(FUNC_WRITE, 16'd3, 16'd3, 64'h0);
		send_element(FUNC_WRITE, 16'd2, 16'd1, 64'h5);
		send_element(FUNC_READ, 16'd2, 16'd1, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd0, {VAL_W{1'b1}});
		send_element(FUNC_READ, 16'd3, 16'd3, 64'h0);
		settle();
		// limit below the count: updates still land, appends refused
		write_register(REG_CAPACITY_LIMIT, 64'd0);
		send_element(FUNC_WRITE, 16'd1, 16'd1, 64'h7);
		send_element(FUNC_WRITE, 16'd3, 16'd3, 64'h9);
		send_element(FUNC_READ, 16'd3, 16'd3, 64'h0);
		settle();
		write_register(REG_NUM_ROWS, 64'd0);
		send_element(FUNC_READ, 16'd0, 16'd0, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h3);
		settle();
		write_register(REG_NUM_ROWS, 64'd4);
		write_register(REG_NUM_COLUMNS, 64'd0);
		send_element(FUNC_READ, 16'd0, 16'd0, 64'h0);
	endtask

	task automatic test_range_edges();
		settle();
		write_register(REG_NUM_ROWS, 64'd65535);
		write_register(REG_NUM_COLUMNS, 64'd65535);
		write_register(REG_DEFAULT_VALUE, 64'h0);
		write_register(REG_CAPACITY_LIMIT, 64'd127);
		send_element(FUNC_WRITE, 16'd65534, 16'd65534, {VAL_W{1'b1}});
		send_element(FUNC_READ, 16'd65534, 16'd65534, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd0, 64'h5555_AAAA_5555_AAAA);
		send_element(FUNC_READ, 16'd65535, 16'd0, 64'h0);
		send_element(FUNC_WRITE, 16'd0, 16'd65535, 64'h1);
	endtask

	task automatic test_random_small_grid();
		settle();
		write_register(REG_NUM_ROWS, 64'd8);
		write_register(REG_NUM_COLUMNS, 64'd8);
		write_register(REG_DEFAULT_VALUE, {$urandom, $urandom});
		write_register(REG_CAPACITY_LIMIT, 64'd64);
		run_random(140);
		settle();
		write_register(REG_NUM_ROWS, 64'd3);
		write_register(REG_NUM_COLUMNS, 64'd5);
		write_register(REG_CAPACITY_LIMIT, 64'd10);
		run_random(80);
	endtask

	task automatic test_backpressure();
		settle();
		write_register(REG_NUM_ROWS, 64'd2);
		write_register(REG_NUM_COLUMNS, 64'd4);
		write_register(REG_CAPACITY_LIMIT, 64'd64);
		src_calm = 1'b1;
		sink_hold = 48;
		for (int k = 0; k < 12; k++)
			send_element(FUNC_WRITE, 16'($urandom_range(0, 1)), 16'($urandom_range(0, 3)),
				{$urandom, $urandom});
		src_calm = 1'b0;
		run_random(20);
	endtask

	task automatic test_random_wide_grid();
		settle();
		write_register(REG_NUM_ROWS, 64'd65535);
		write_register(REG_NUM_COLUMNS, 64'd65535);
		write_register(REG_DEFAULT_VALUE, {VAL_W{1'b1}});
		run_random(60);
	endtask

	task automatic test_random_mixed_settings();
		for (int p = 0; p < 3; p++) begin
			settle();
			write_register(REG_NUM_ROWS, 64'($urandom_range(1, 12)));
			write_register(REG_NUM_COLUMNS, 64'($urandom_range(1, 12)));
			write_register(REG_DEFAULT_VALUE, (p == 1) ? 64'h0 : {$urandom, $urandom});
			write_register(REG_CAPACITY_LIMIT, 64'($urandom_range(0, 70)));
			run_random(40);
		end
	endtask

	// receiver: random stalls per result, calm stretches, and a long hold when asked
	initial begin : result_sink
		int unsigned gap;
		bit          sink_calm;
		m_tready = 1'b0;
		sink_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold != 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end else begin
				if ($urandom_range(0, 15) == 0)
					sink_calm = !sink_calm;
				gap = sink_calm ? 0 : $urandom_range(0, 7);
			end
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_result
		element_result_t got;
		element_result_t want;
		logic [OUT_PAD_W-1:0] pad;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_value = m_tdata[63:0];
			got.found = m_tdata[64];
			got.status = m_tdata[66:65];
			got.entry_total = m_tdata[73:67];
			pad = m_tdata[OUT_DATA_W-1:74];
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%t: result transfer with no request pending: %h", $realtime, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got !== want || pad !== '0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%t: mismatch, expected value %h found %b status %0d total %0d",
							$realtime, want.read_value, want.found, want.status, want.entry_total);
						$display("%t:           got value %h found %b status %0d total %0d pad %h",
							$realtime, got.read_value, got.found, got.status, got.entry_total, pad);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
					quiet, pending_results.size());
				$display("sparse_matrix_element_store_test: done, errors");
				$finish;
			end
		end
	end

	initial begin : run_tests
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_NUM_ROWS;
		cfg_data = '0;
		cur_rows = 16'd1;
		cur_cols = 16'd1;
		cur_default = '0;
		cur_limit = 7'd64;
		live_entries = 0;
		peak_entries = 0;
		src_calm = 1'b0;
		sink_hold = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_access();
		test_capacity_and_delete();
		test_range_edges();
		test_random_small_grid();
		test_backpressure();
		test_random_wide_grid();
		test_random_mixed_settings();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			mismatch_count++;

		$display("covered %0d reads and %0d writes, %0d results checked, %0d mismatches",
			read_count, write_count, results_checked, mismatch_count);
		$display("out of range %0d, table full %0d, deletes %0d, peak entries %0d",
			range_count, full_count, delete_count, peak_entries);
		if (mismatch_count == 0)
			$display("sparse_matrix_element_store_test: done, clean");
		else
			$display("sparse_matrix_element_store_test: done, errors");
		$finish;
	end

endmodule
